[src/bounded_deque_unit_assert.svh]
// ----------------------------------------------------------------------------
// Bounded deque assertion macros
// Shared property wrappers for the deque checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BDQ_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded deque assertion failed");

// Next-cycle implication, disabled during reset.
`define BDQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounded deque assertion failed");

// Next-cycle implication that also holds across reset.
`define BDQ_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bounded deque assertion failed");

`endif

[src/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// Bounded deque package
// Transaction types, operation and status codes, and cell commands.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;
  localparam logic [2:0] OP_DUMP       = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] element;
    logic [4:0]  count;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_SHIFT_LEFT,
    CMD_ROTATE
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

endpackage

[src/bdq_cell.sv]
// ----------------------------------------------------------------------------
// Bounded deque cell
// One storage slot of the deque, ordered from the front, exchanging its
// word with its neighbors on front pushes, front pops and dump rotation.
// ----------------------------------------------------------------------------
module bdq_cell #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
  parameter int IDX   = 0,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  bdq_pkg::cell_cmd_t cmd,
  input  logic [CW-1:0]      count,
  input  logic [31:0]        value,
  input  logic [31:0]        left,
  input  logic [31:0]        right,
  input  logic [31:0]        head,
  output logic [31:0]        data
);
  import bdq_pkg::*;

  localparam logic [CW-1:0] POS      = CW'(IDX);
  localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);

  logic [31:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd)
      CMD_PUSH_FRONT: begin
        data_next = (IDX == 0) ? value : left;
      end
      CMD_PUSH_BACK: begin
        if (count == POS) begin
          data_next = value;
        end
      end
      CMD_SHIFT_LEFT: begin
        data_next = right;
      end
      CMD_ROTATE: begin
        if (count == POS_NEXT) begin
          data_next = head;
        end else if (POS_NEXT < count) begin
          data_next = right;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[src/bounded_deque_unit.sv]
// ----------------------------------------------------------------------------
// Bounded deque unit
// Double-ended queue of up to DEPTH 32-bit words held in a row of cells.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_ready, req) carries an operation and a
// value. The response channel (rsp_valid, rsp_ready, rsp) returns a status,
// an element, the element count after the operation, and a last flag.
// Outside a dump, cell 0 holds the front element and cell count-1 the back.
// Push, pop, clear and unused codes give one response on the following
// cycle; one request is accepted per cycle while responses are taken as
// they appear.
// A dump of N stored elements first enters the walk and then gives one
// response per element; at each step, while the response slot is free, the
// cell row rotates by one position and cell 0 is copied to the response
// register. No request is accepted during a dump.
// A synchronous reset empties the deque and drops any pending response.
// When the receiver stalls, the response register holds its transaction and
// req_ready stays low until the response is taken.
// ----------------------------------------------------------------------------
module bounded_deque_unit #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bdq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bdq_pkg::rsp_t rsp
);
  import bdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0]   cells [DEPTH];
  cell_cmd_t     cmd;
  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic          rsp_valid_next;
  rsp_t          rsp_next;
  logic          slot_free;
  logic          accept;
  logic          full;
  logic          empty;
  logic          walk_end;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && slot_free;
  assign accept    = req_valid && req_ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign walk_end  = (idx == count - CW'(1));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bdq_cell #(
      .DEPTH (DEPTH),
      .IDX   (i),
      .CW    (CW)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .count (count),
      .value (req.value),
      .left  ((i == 0) ? cells[0] : cells[(i == 0) ? 0 : i - 1]),
      .right ((i == DEPTH - 1) ? cells[DEPTH - 1] : cells[(i == DEPTH - 1) ? i : i + 1]),
      .head  (cells[0]),
      .data  (cells[i])
    );
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              if (!full) begin
                count_next = count + CW'(1);
              end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
              if (!empty) begin
                count_next = count - CW'(1);
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_DUMP: begin
              if (!empty) begin
                state_next = S_DUMP;
                idx_next   = '0;
              end
            end
            default: begin
              count_next = count;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          idx_next = idx + CW'(1);
          if (walk_end) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = CMD_HOLD;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    case (state)
      S_IDLE: begin
        if (accept) begin
          rsp_valid_next   = 1'b1;
          rsp_next.status  = ST_OK;
          rsp_next.element = '0;
          rsp_next.count   = 5'(count_next);
          rsp_next.last    = 1'b1;
          case (req.op)
            OP_PUSH_BACK: begin
              if (full) begin
                rsp_next.status = ST_FULL;
              end else begin
                cmd = CMD_PUSH_BACK;
              end
            end
            OP_PUSH_FRONT: begin
              if (full) begin
                rsp_next.status = ST_FULL;
              end else begin
                cmd = CMD_PUSH_FRONT;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                rsp_next.status = ST_EMPTY;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                cmd = CMD_SHIFT_LEFT;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                rsp_valid_next = 1'b0;
              end
            end
            default: begin
              rsp_next.status = ST_OK;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          cmd              = CMD_ROTATE;
          rsp_valid_next   = 1'b1;
          rsp_next.status  = ST_OK;
          rsp_next.element = cells[0];
          rsp_next.count   = 5'(count);
          rsp_next.last    = walk_end;
        end
      end
      default: begin
        cmd = CMD_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule

[src/bdq_checker.sv]
// ----------------------------------------------------------------------------
// Bounded deque checker
// Port-level properties of the deque unit, attached by bind.
// ----------------------------------------------------------------------------
`include "bounded_deque_unit_assert.svh"

module bdq_checker #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input bdq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input bdq_pkg::rsp_t rsp
);
  import bdq_pkg::*;

  logic req_seen;

  assign req_seen = req_valid && req_ready;

  `BDQ_ASSERT_NEXT(a_req_hold, clk, rst, req_valid && !req_ready, req_valid && $stable(req))
  `BDQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `BDQ_ASSERT_IMP(a_full_rsp, clk, rst, rsp_valid && rsp.status == ST_FULL,
                  rsp.last && rsp.element == '0 && rsp.count == 5'(DEPTH))
  `BDQ_ASSERT_IMP(a_empty_rsp, clk, rst, rsp_valid && rsp.status == ST_EMPTY,
                  rsp.last && rsp.element == '0 && rsp.count == '0)
  `BDQ_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !rsp_valid && !req_seen)

endmodule

bind bounded_deque_unit bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (.*);
